// ===== rtl/lma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lma_pkg
// Shared widths, defaults and register indexes of the moving average filter.
// ----------------------------------------------------------------------------
package lma_pkg;

	// defaults of the top level parameters
	localparam int unsigned DEFAULT_MAX_WINDOW  = 256;
	localparam int unsigned DEFAULT_SAMPLE_BITS = 32;

	// fixed widths of the datapath
	localparam int unsigned LEN_BITS   = 9;
	localparam int unsigned RECIP_BITS = 33;
	localparam int unsigned WSUM_BITS  = 48;
	localparam int unsigned PSUM_BITS  = 40;
	localparam int unsigned OUT_BITS   = 51;
	localparam int unsigned FRAC_SHIFT = 16;

	// operand split for the reciprocal multiplies
	localparam int unsigned WS_LO_BITS = WSUM_BITS / 2;
	localparam int unsigned WS_HI_BITS = WSUM_BITS - WS_LO_BITS;
	localparam int unsigned PS_LO_BITS = PSUM_BITS / 2;
	localparam int unsigned PS_HI_BITS = PSUM_BITS - PS_LO_BITS;

	// configuration port
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS  = RECIP_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_WEIGHT_SUM_RECIP = 2'd1,
		REG_LENGTH_RECIP = 2'd2
	} lma_reg_index_t;

	localparam logic [LEN_BITS-1:0]   WINDOW_LENGTH_RESET = LEN_BITS'(1);
	localparam logic [RECIP_BITS-1:0] RECIP_RESET = {1'b1, {(RECIP_BITS-1){1'b0}}};

endpackage

`default_nettype wire

// ===== rtl/lma_moving_average_filter.sv =====
`default_nettype none
// an accepted sample passes the stage registers, then the result register
// one sample per cycle unless stalled; running sums close their loop in one stage
// the first window_length-1 samples after reset give no result
// reset clears the sums, the warm-up count, the ring pointer and all valid bits;
// the configuration returns to length 1 with both reciprocals at 1.0
// ----------------------------------------------------------------------------
// lma_moving_average_filter
// Streaming 2*WMA - SMA filter with a sample ring and a pipelined Q.16 output.
// ----------------------------------------------------------------------------
module lma_moving_average_filter
	import lma_pkg::*;
#(
	parameter int unsigned MAX_WINDOW  = DEFAULT_MAX_WINDOW,
	parameter int unsigned SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire        [CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire        [CFG_DATA_BITS-1:0]   cfg_data,
	input  wire                              sample_valid,
	output logic                             sample_ready,
	input  wire signed [SAMPLE_BITS-1:0]     sample,
	output logic                             result_valid,
	input  wire                              result_ready,
	output logic signed [OUT_BITS-1:0]       average_value
);

	localparam int unsigned PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned SUM_W   = PTR_W + 2;
	localparam int unsigned LEN_MAX = 2 ** LEN_BITS - 1;
	localparam int unsigned LEN_CAP = (MAX_WINDOW < LEN_MAX) ? MAX_WINDOW : LEN_MAX;
	localparam logic [LEN_BITS-1:0] LEN_CAP_V = LEN_BITS'(LEN_CAP);
	localparam int unsigned WX_BITS = LEN_BITS + 1 + SAMPLE_BITS;
	localparam int unsigned P_BITS  = WSUM_BITS + RECIP_BITS;
	localparam int unsigned Q_BITS  = PSUM_BITS + RECIP_BITS;
	localparam int unsigned D_BITS  = P_BITS + 2;
	localparam int unsigned SH_BITS = D_BITS - FRAC_SHIFT;
	localparam int unsigned PPWL_BITS = WS_LO_BITS + RECIP_BITS;
	localparam int unsigned PPWH_BITS = WS_HI_BITS + RECIP_BITS + 1;
	localparam int unsigned PPPL_BITS = PS_LO_BITS + RECIP_BITS;
	localparam int unsigned PPPH_BITS = PS_HI_BITS + RECIP_BITS + 1;

	// configuration registers
	logic [LEN_BITS-1:0]   window_length_q;
	logic [RECIP_BITS-1:0] weight_sum_recip_q;
	logic [RECIP_BITS-1:0] length_recip_q;

	// running state
	logic signed [WSUM_BITS-1:0] weighted_sum_q;
	logic signed [PSUM_BITS-1:0] plain_sum_q;
	logic [LEN_BITS-1:0]         warmup_count_q;
	logic [PTR_W-1:0]            ring_ptr_q;
	logic [SAMPLE_BITS-1:0]      sample_ring_q [MAX_WINDOW];

	// pipeline valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_valid_q;

	// stage 1
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic [LEN_BITS-1:0]           w_s1;
	logic                          steady_s1;
	logic                          bypass_s1;
	logic [SAMPLE_BITS-1:0]        old_rd_s1;
	// stage 2
	logic signed [WX_BITS-1:0]     wx_s2;
	logic signed [SAMPLE_BITS-1:0] x_s2;
	logic signed [SAMPLE_BITS-1:0] old_s2;
	logic                          steady_s2;
	// stage 3
	logic signed [WSUM_BITS-1:0]   ws_s3;
	logic signed [PSUM_BITS-1:0]   ps_s3;
	// stage 4
	logic [PPWL_BITS-1:0]          ppwl_s4;
	logic signed [PPWH_BITS-1:0]   ppwh_s4;
	logic [PPPL_BITS-1:0]          pppl_s4;
	logic signed [PPPH_BITS-1:0]   ppph_s4;
	// stage 5
	logic signed [P_BITS-1:0]      p_s5;
	logic signed [Q_BITS-1:0]      q_s5;
	// stage 6
	logic signed [D_BITS-1:0]      d_s6;
	// result register
	logic signed [OUT_BITS-1:0]    average_q;

	// handshake
	logic free_o, free_s6, free_s5, free_s4, free_s3, free_s2, free_s1;
	logic leave_o, leave_s6, leave_s5, leave_s4, leave_s3, leave_s2, leave_s1, go_s3;
	logic accept;

	// accept side control
	logic [LEN_BITS-1:0] len_eff;
	logic [LEN_BITS-1:0] len_m1;
	logic                steady_in;
	logic [LEN_BITS-1:0] weight_in;
	logic [SUM_W-1:0]    old_sum;
	logic [SUM_W-1:0]    old_sum_wrap;
	logic [PTR_W-1:0]    old_idx;
	logic [PTR_W-1:0]    ring_ptr_next;

	// stage 2 sums
	logic signed [WSUM_BITS-1:0] ws1;
	logic signed [PSUM_BITS-1:0] ps1;

	// stage 5 / 6 helpers
	logic signed [P_BITS-1:0] p_hi_ext, p_lo_ext;
	logic signed [Q_BITS-1:0] q_hi_ext, q_lo_ext;
	logic signed [SH_BITS-1:0] shifted;
	logic                      fits;
	logic signed [OUT_BITS-1:0] saturated;

	// ------------------------------------------------------------------------
	// handshake: each stage loads when it is empty or its content moves on
	// ------------------------------------------------------------------------
	always_comb begin
		free_o   = !out_valid_q || result_ready;
		leave_o  = out_valid_q && result_ready;
		free_s6  = !v_s6 || free_o;
		leave_s6 = v_s6 && free_o;
		free_s5  = !v_s5 || free_s6;
		leave_s5 = v_s5 && free_s6;
		free_s4  = !v_s4 || free_s5;
		leave_s4 = v_s4 && free_s5;
		free_s3  = !v_s3 || free_s4;
		leave_s3 = v_s3 && free_s4;
		// warm-up requests retire after the sum update
		free_s2  = !v_s2 || !steady_s2 || free_s3;
		leave_s2 = v_s2 && (!steady_s2 || free_s3);
		go_s3    = v_s2 && steady_s2 && free_s3;
		free_s1  = !v_s1 || free_s2;
		leave_s1 = v_s1 && free_s2;
		accept   = sample_valid && free_s1;
	end

	assign sample_ready  = free_s1;
	assign result_valid  = out_valid_q;
	assign average_value = average_q;

	// ------------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q    <= WINDOW_LENGTH_RESET;
			weight_sum_recip_q <= RECIP_RESET;
			length_recip_q     <= RECIP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH:    window_length_q    <= cfg_data[LEN_BITS-1:0];
				REG_WEIGHT_SUM_RECIP: weight_sum_recip_q <= cfg_data;
				REG_LENGTH_RECIP:     length_recip_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// accept side: warm-up count, weight and ring addressing
	// ------------------------------------------------------------------------
	always_comb begin
		if (window_length_q == '0) begin
			len_eff = LEN_BITS'(1);
		end else if (window_length_q > LEN_CAP_V) begin
			len_eff = LEN_CAP_V;
		end else begin
			len_eff = window_length_q;
		end
		len_m1    = len_eff - LEN_BITS'(1);
		steady_in = (warmup_count_q >= len_m1);
		weight_in = steady_in ? len_eff : (warmup_count_q + LEN_BITS'(1));

		// oldest window entry sits len-1 places behind the write pointer
		old_sum = SUM_W'(ring_ptr_q) + SUM_W'(MAX_WINDOW) - SUM_W'(len_m1);
		if (old_sum >= SUM_W'(MAX_WINDOW)) begin
			old_sum_wrap = old_sum - SUM_W'(MAX_WINDOW);
		end else begin
			old_sum_wrap = old_sum;
		end
		old_idx = old_sum_wrap[PTR_W-1:0];

		if (ring_ptr_q == PTR_W'(MAX_WINDOW - 1)) begin
			ring_ptr_next = '0;
		end else begin
			ring_ptr_next = ring_ptr_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_count_q <= '0;
			ring_ptr_q     <= '0;
		end else if (accept) begin
			if (!steady_in) begin
				warmup_count_q <= warmup_count_q + LEN_BITS'(1);
			end
			ring_ptr_q <= ring_ptr_next;
		end
	end

	// sample ring: write the new sample, read the oldest one (read before write)
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_ring_q[ring_ptr_q] <= sample;
			old_rd_s1 <= sample_ring_q[old_idx];
		end
	end

	// ------------------------------------------------------------------------
	// valid bits
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= accept   || (v_s1 && !leave_s1);
			v_s2        <= leave_s1 || (v_s2 && !leave_s2);
			v_s3        <= go_s3    || (v_s3 && !leave_s3);
			v_s4        <= leave_s3 || (v_s4 && !leave_s4);
			v_s5        <= leave_s4 || (v_s5 && !leave_s5);
			v_s6        <= leave_s5 || (v_s6 && !leave_s6);
			out_valid_q <= leave_s6 || (out_valid_q && !leave_o);
		end
	end

	// ------------------------------------------------------------------------
	// stage 1 -> 2: weight times sample, pick the sample leaving the window
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1      <= sample;
			w_s1      <= weight_in;
			steady_s1 <= steady_in;
			// window of one: the leaving sample is the one just written
			bypass_s1 <= (len_m1 == '0);
		end
		if (leave_s1) begin
			wx_s2     <= $signed({1'b0, w_s1}) * x_s1;
			x_s2      <= x_s1;
			old_s2    <= bypass_s1 ? x_s1 : $signed(old_rd_s1);
			steady_s2 <= steady_s1;
		end
	end

	// ------------------------------------------------------------------------
	// stage 2: running sum update
	// ------------------------------------------------------------------------
	always_comb begin
		ws1 = weighted_sum_q + WSUM_BITS'(wx_s2);
		ps1 = plain_sum_q + PSUM_BITS'(x_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_sum_q <= '0;
			plain_sum_q    <= '0;
		end else if (leave_s2) begin
			if (steady_s2) begin
				// every weight drops by one, oldest sample leaves the plain sum
				weighted_sum_q <= ws1 - WSUM_BITS'(ps1);
				plain_sum_q    <= ps1 - PSUM_BITS'(old_s2);
			end else begin
				weighted_sum_q <= ws1;
				plain_sum_q    <= ps1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s3) begin
			ws_s3 <= ws1;
			ps_s3 <= ps1;
		end
	end

	// ------------------------------------------------------------------------
	// stage 3 -> 4: partial products with the reciprocals
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (leave_s3) begin
			ppwl_s4 <= PPWL_BITS'(ws_s3[WS_LO_BITS-1:0]) * PPWL_BITS'(weight_sum_recip_q);
			ppwh_s4 <= $signed(ws_s3[WSUM_BITS-1:WS_LO_BITS])
				* $signed({1'b0, weight_sum_recip_q});
			pppl_s4 <= PPPL_BITS'(ps_s3[PS_LO_BITS-1:0]) * PPPL_BITS'(length_recip_q);
			ppph_s4 <= $signed(ps_s3[PSUM_BITS-1:PS_LO_BITS])
				* $signed({1'b0, length_recip_q});
		end
	end

	// ------------------------------------------------------------------------
	// stage 4 -> 5: assemble the two products
	// ------------------------------------------------------------------------
	always_comb begin
		p_hi_ext = P_BITS'(ppwh_s4);
		p_lo_ext = $signed(P_BITS'(ppwl_s4));
		q_hi_ext = Q_BITS'(ppph_s4);
		q_lo_ext = $signed(Q_BITS'(pppl_s4));
	end

	always_ff @(posedge clk) begin
		if (leave_s4) begin
			p_s5 <= (p_hi_ext <<< WS_LO_BITS) + p_lo_ext;
			q_s5 <= (q_hi_ext <<< PS_LO_BITS) + q_lo_ext;
		end
	end

	// ------------------------------------------------------------------------
	// stage 5 -> 6: 2*weighted term minus plain term
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (leave_s5) begin
			d_s6 <= (D_BITS'(p_s5) <<< 1) - D_BITS'(q_s5);
		end
	end

	// ------------------------------------------------------------------------
	// stage 6 -> result: drop the fraction (floor) and saturate
	// ------------------------------------------------------------------------
	always_comb begin
		shifted = d_s6[D_BITS-1:FRAC_SHIFT];
		fits    = (shifted[SH_BITS-1:OUT_BITS-1] == '0)
			|| (shifted[SH_BITS-1:OUT_BITS-1] == '1);
		if (fits) begin
			saturated = shifted[OUT_BITS-1:0];
		end else if (shifted[SH_BITS-1]) begin
			saturated = {1'b1, {(OUT_BITS-1){1'b0}}};
		end else begin
			saturated = {1'b0, {(OUT_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s6) begin
			average_q <= saturated;
		end
	end

endmodule

`default_nettype wire
